FILE: hdl/pcm_pkg.sv
`default_nettype none

package pcm_pkg;

    // default store sizes
    localparam int CORRIDOR_DEPTH_DEF = 256;
    localparam int VISITED_DEPTH_DEF  = 16;

    // field widths
    localparam int REF_W    = 32;
    localparam int LEN_W    = 9;
    localparam int IDX_W    = 8;
    localparam int VCOUNT_W = 5;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 9'd256;

    // action codes
    localparam logic [1:0] ACT_WR_COR = 2'd0;
    localparam logic [1:0] ACT_WR_VIS = 2'd1;
    localparam logic [1:0] ACT_MERGE  = 2'd2;
    localparam logic [1:0] ACT_RD_COR = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [IDX_W-1:0]    index;
        logic [REF_W-1:0]    ref_req;
        logic [LEN_W-1:0]    path_count;
        logic [VCOUNT_W-1:0] visited_count;
    } pcm_in_t;

    typedef struct packed {
        logic [REF_W-1:0] read_ref;
        logic [LEN_W-1:0] new_length;
        logic             merged;
    } pcm_out_t;

endpackage

`default_nettype wire

FILE: hdl/pcm_corridor_mem.sv
`default_nettype none

module pcm_corridor_mem #(
    parameter int DEPTH = pcm_pkg::CORRIDOR_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [pcm_pkg::REF_W-1:0] wdata,
    input  wire logic                     re,
    input  wire logic [AW-1:0]            raddr,
    output logic      [pcm_pkg::REF_W-1:0] rdata
);
    import pcm_pkg::*;

    logic [REF_W-1:0] mem [DEPTH];
    logic [REF_W-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/pcm_visited_file.sv
`default_nettype none

module pcm_visited_file #(
    parameter int DEPTH = pcm_pkg::VISITED_DEPTH_DEF,
    parameter int VW    = $clog2(DEPTH),
    parameter int VCW   = $clog2(DEPTH + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [VW-1:0]             waddr,
    input  wire logic [pcm_pkg::REF_W-1:0] wdata,
    input  wire logic [VCW-1:0]            count,
    input  wire logic [pcm_pkg::REF_W-1:0] cmp_data,
    output logic                           hit,
    output logic      [VW-1:0]             hit_idx,
    input  wire logic [VW-1:0]             raddr,
    output logic      [pcm_pkg::REF_W-1:0] rdata
);
    import pcm_pkg::*;

    logic [REF_W-1:0] entry [DEPTH];
    logic [DEPTH-1:0] match;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry[waddr] <= wdata;
        end
    end

    // compare every live entry against the corridor word at once
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            match[j] = (VCW'(j) < count) && (entry[j] == cmp_data);
        end
    end

    // lowest matching entry wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int j = DEPTH - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                hit     = 1'b1;
                hit_idx = VW'(j);
            end
        end
    end

    assign rdata = entry[raddr];

endmodule

`default_nettype wire

FILE: hdl/pcm_merge_ctrl.sv
`default_nettype none

module pcm_merge_ctrl #(
    parameter int CORRIDOR_DEPTH = pcm_pkg::CORRIDOR_DEPTH_DEF,
    parameter int VISITED_DEPTH  = pcm_pkg::VISITED_DEPTH_DEF,
    parameter int AW             = $clog2(CORRIDOR_DEPTH),
    parameter int VW             = $clog2(VISITED_DEPTH),
    parameter int VCW            = $clog2(VISITED_DEPTH + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire pcm_pkg::pcm_in_t          req_word,
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output pcm_pkg::pcm_out_t              rsp_word,
    input  wire logic                      cfg_we,
    input  wire logic [pcm_pkg::LEN_W-1:0] cfg_data,
    output logic                           cor_we,
    output logic      [AW-1:0]             cor_waddr,
    output logic      [pcm_pkg::REF_W-1:0] cor_wdata,
    output logic                           cor_re,
    output logic      [AW-1:0]             cor_raddr,
    input  wire logic [pcm_pkg::REF_W-1:0] cor_rdata,
    output logic                           vis_we,
    output logic      [VW-1:0]             vis_waddr,
    output logic      [pcm_pkg::REF_W-1:0] vis_wdata,
    output logic      [VCW-1:0]            vis_count,
    input  wire logic                      vis_hit,
    input  wire logic [VW-1:0]             vis_hit_idx,
    output logic      [VW-1:0]             vis_raddr,
    input  wire logic [pcm_pkg::REF_W-1:0] vis_rdata
);
    import pcm_pkg::*;

    localparam int CW = $clog2(CORRIDOR_DEPTH + 1);
    localparam int NW = (CW > 10) ? CW : 10;
    localparam logic [NW-1:0] CD_N = NW'(CORRIDOR_DEPTH);
    localparam logic [NW-1:0] VD_N = NW'(VISITED_DEPTH);
    localparam logic [NW-1:0] ONE  = NW'(1);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_RDWAIT = 8'b0000_0010,
        ST_SCAN   = 8'b0000_0100,
        ST_CALC1  = 8'b0000_1000,
        ST_CALC2  = 8'b0001_0000,
        ST_CALC3  = 8'b0010_0000,
        ST_COPY   = 8'b0100_0000,
        ST_PREFIX = 8'b1000_0000
    } state_t;

    // control registers
    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   max_len_reg, max_len_next;
    logic [LEN_W-1:0]   last_len_reg, last_len_next;
    logic               last_merged_reg, last_merged_next;
    logic               pend_rd_reg, pend_rd_next;
    logic               wb_valid_reg, wb_valid_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               hold_valid_reg, hold_valid_next;

    // datapath registers
    logic [NW-1:0]      npath_reg, npath_next;
    logic [VCW-1:0]     nvis_reg, nvis_next;
    logic [NW-1:0]      limit_reg, limit_next;
    logic [NW-1:0]      issue_reg, issue_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic [AW-1:0]      hit_path_reg, hit_path_next;
    logic [VW-1:0]      hit_vis_reg, hit_vis_next;
    logic [NW-1:0]      req_len_reg, req_len_next;
    logic [NW-1:0]      tail_reg, tail_next;
    logic [NW-1:0]      total_reg, total_next;
    logic [AW-1:0]      cp_src_reg, cp_src_next;
    logic [AW-1:0]      cp_dst_reg, cp_dst_next;
    logic [NW-1:0]      cp_left_reg, cp_left_next;
    logic               bwd_reg, bwd_next;
    logic [AW-1:0]      wb_addr_reg, wb_addr_next;
    logic [AW-1:0]      pre_addr_reg, pre_addr_next;
    logic [VW-1:0]      pre_vis_reg, pre_vis_next;
    logic [NW-1:0]      pre_left_reg, pre_left_next;
    logic               rd_oob_reg, rd_oob_next;
    pcm_out_t           rsp_word_reg, rsp_word_next;
    pcm_out_t           hold_word_reg, hold_word_next;

    logic               accept;
    logic               produce;
    logic               out_free;
    pcm_out_t           res_word;
    logic [NW-1:0]      idx_n;
    logic [NW-1:0]      pc_n;
    logic [NW-1:0]      vc_n;
    logic [NW-1:0]      ml_n;
    logic [NW-1:0]      req_raw;
    logic [NW-1:0]      room;

    assign req_stall = (state_reg != ST_IDLE) || hold_valid_reg;
    assign accept    = req_valid && !req_stall;
    assign idx_n     = NW'(req_word.index);
    assign pc_n      = NW'(req_word.path_count);
    assign vc_n      = NW'(req_word.visited_count);
    assign ml_n      = NW'(max_len_reg);
    assign req_raw   = NW'(nvis_reg) - NW'(hit_vis_reg);
    assign room      = limit_reg - req_len_reg;
    assign vis_count = nvis_reg;
    assign vis_raddr = pre_vis_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // sequencer: actions, match scan, tail move, visited prefix
    always_comb
    begin
        state_next       = state_reg;
        max_len_next     = cfg_we ? cfg_data : max_len_reg;
        last_len_next    = last_len_reg;
        last_merged_next = last_merged_reg;
        pend_rd_next     = pend_rd_reg;
        wb_valid_next    = wb_valid_reg;
        npath_next       = npath_reg;
        nvis_next        = nvis_reg;
        limit_next       = limit_reg;
        issue_next       = issue_reg;
        pend_addr_next   = pend_addr_reg;
        hit_path_next    = hit_path_reg;
        hit_vis_next     = hit_vis_reg;
        req_len_next     = req_len_reg;
        tail_next        = tail_reg;
        total_next       = total_reg;
        cp_src_next      = cp_src_reg;
        cp_dst_next      = cp_dst_reg;
        cp_left_next     = cp_left_reg;
        bwd_next         = bwd_reg;
        wb_addr_next     = wb_addr_reg;
        pre_addr_next    = pre_addr_reg;
        pre_vis_next     = pre_vis_reg;
        pre_left_next    = pre_left_reg;
        rd_oob_next      = rd_oob_reg;
        cor_we           = 1'b0;
        cor_waddr        = '0;
        cor_wdata        = '0;
        cor_re           = 1'b0;
        cor_raddr        = '0;
        vis_we           = 1'b0;
        vis_waddr        = '0;
        vis_wdata        = '0;
        produce          = 1'b0;
        res_word         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_word.action)
                        ACT_WR_COR:
                        begin
                            cor_we    = idx_n < CD_N;
                            cor_waddr = AW'(idx_n);
                            cor_wdata = req_word.ref_req;
                            produce   = 1'b1;
                        end
                        ACT_WR_VIS:
                        begin
                            vis_we    = idx_n < VD_N;
                            vis_waddr = VW'(idx_n);
                            vis_wdata = req_word.ref_req;
                            produce   = 1'b1;
                        end
                        ACT_MERGE:
                        begin
                            npath_next   = (pc_n > CD_N) ? CD_N : pc_n;
                            issue_next   = (pc_n > CD_N) ? CD_N : pc_n;
                            nvis_next    = (vc_n > VD_N) ? VCW'(VD_N) : VCW'(vc_n);
                            limit_next   = (ml_n > CD_N) ? CD_N : ml_n;
                            pend_rd_next = 1'b0;
                            state_next   = ST_SCAN;
                        end
                        ACT_RD_COR:
                        begin
                            cor_re      = 1'b1;
                            cor_raddr   = AW'(idx_n);
                            rd_oob_next = !(idx_n < CD_N);
                            state_next  = ST_RDWAIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_RDWAIT:
            begin
                produce           = 1'b1;
                res_word.read_ref = rd_oob_reg ? '0 : cor_rdata;
                state_next        = ST_IDLE;
            end

            // walk the corridor from the end, one read in flight
            ST_SCAN:
            begin
                if (pend_rd_reg && vis_hit)
                begin
                    hit_path_next = pend_addr_reg;
                    hit_vis_next  = vis_hit_idx;
                    pend_rd_next  = 1'b0;
                    state_next    = ST_CALC1;
                end
                else if (issue_reg != '0)
                begin
                    cor_re         = 1'b1;
                    cor_raddr      = AW'(issue_reg - ONE);
                    pend_addr_next = AW'(issue_reg - ONE);
                    issue_next     = issue_reg - ONE;
                    pend_rd_next   = 1'b1;
                end
                else
                begin
                    // no common entry
                    last_len_next    = npath_reg[LEN_W-1:0];
                    last_merged_next = 1'b0;
                    pend_rd_next     = 1'b0;
                    produce          = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            ST_CALC1:
            begin
                req_len_next = (req_raw > limit_reg) ? limit_reg : req_raw;
                tail_next    = npath_reg - NW'(hit_path_reg) - ONE;
                state_next   = ST_CALC2;
            end

            ST_CALC2:
            begin
                tail_next  = (tail_reg > room) ? room : tail_reg;
                state_next = ST_CALC3;
            end

            // tail moves up when the prefix is longer than the dropped head
            ST_CALC3:
            begin
                total_next    = req_len_reg + tail_reg;
                bwd_next      = req_len_reg > (NW'(hit_path_reg) + ONE);
                cp_left_next  = tail_reg;
                wb_valid_next = 1'b0;
                if (req_len_reg > (NW'(hit_path_reg) + ONE))
                begin
                    cp_src_next = AW'(NW'(hit_path_reg) + tail_reg);
                    cp_dst_next = AW'(req_len_reg + tail_reg - ONE);
                end
                else
                begin
                    cp_src_next = AW'(NW'(hit_path_reg) + ONE);
                    cp_dst_next = AW'(req_len_reg);
                end
                state_next = ST_COPY;
            end

            // read one tail word per cycle, write it back the cycle after
            ST_COPY:
            begin
                if (wb_valid_reg)
                begin
                    cor_we    = 1'b1;
                    cor_waddr = wb_addr_reg;
                    cor_wdata = cor_rdata;
                end
                if (cp_left_reg != '0)
                begin
                    cor_re        = 1'b1;
                    cor_raddr     = cp_src_reg;
                    wb_valid_next = 1'b1;
                    wb_addr_next  = cp_dst_reg;
                    cp_left_next  = cp_left_reg - ONE;
                    cp_src_next   = bwd_reg ? cp_src_reg - AW'(1) : cp_src_reg + AW'(1);
                    cp_dst_next   = bwd_reg ? cp_dst_reg - AW'(1) : cp_dst_reg + AW'(1);
                end
                else
                begin
                    wb_valid_next = 1'b0;
                    if (!wb_valid_reg)
                    begin
                        pre_addr_next = '0;
                        pre_vis_next  = VW'(NW'(nvis_reg) - ONE);
                        pre_left_next = req_len_reg;
                        state_next    = ST_PREFIX;
                    end
                end
            end

            // visited entries, last first, into the head of the corridor
            ST_PREFIX:
            begin
                if (pre_left_reg != '0)
                begin
                    cor_we        = 1'b1;
                    cor_waddr     = pre_addr_reg;
                    cor_wdata     = vis_rdata;
                    pre_addr_next = pre_addr_reg + AW'(1);
                    pre_vis_next  = pre_vis_reg - VW'(1);
                    pre_left_next = pre_left_reg - ONE;
                end
                else
                begin
                    last_len_next    = total_reg[LEN_W-1:0];
                    last_merged_next = 1'b1;
                    produce          = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_word.new_length = last_len_next;
        res_word.merged     = last_merged_next;
    end

    // output register with one holding slot behind it
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_word_next   = rsp_word_reg;
        hold_valid_next = hold_valid_reg;
        hold_word_next  = hold_word_reg;
        if (out_free)
        begin
            if (hold_valid_reg)
            begin
                rsp_word_next   = hold_word_reg;
                rsp_valid_next  = 1'b1;
                hold_valid_next = 1'b0;
            end
            else if (produce)
            begin
                rsp_word_next  = res_word;
                rsp_valid_next = 1'b1;
            end
            else
            begin
                rsp_valid_next = 1'b0;
            end
        end
        else if (produce)
        begin
            hold_word_next  = res_word;
            hold_valid_next = 1'b1;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            max_len_reg     <= MAX_LENGTH_RST;
            last_len_reg    <= '0;
            last_merged_reg <= 1'b0;
            pend_rd_reg     <= 1'b0;
            wb_valid_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            hold_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            max_len_reg     <= max_len_next;
            last_len_reg    <= last_len_next;
            last_merged_reg <= last_merged_next;
            pend_rd_reg     <= pend_rd_next;
            wb_valid_reg    <= wb_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            hold_valid_reg  <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        npath_reg     <= npath_next;
        nvis_reg      <= nvis_next;
        limit_reg     <= limit_next;
        issue_reg     <= issue_next;
        pend_addr_reg <= pend_addr_next;
        hit_path_reg  <= hit_path_next;
        hit_vis_reg   <= hit_vis_next;
        req_len_reg   <= req_len_next;
        tail_reg      <= tail_next;
        total_reg     <= total_next;
        cp_src_reg    <= cp_src_next;
        cp_dst_reg    <= cp_dst_next;
        cp_left_reg   <= cp_left_next;
        bwd_reg       <= bwd_next;
        wb_addr_reg   <= wb_addr_next;
        pre_addr_reg  <= pre_addr_next;
        pre_vis_reg   <= pre_vis_next;
        pre_left_reg  <= pre_left_next;
        rd_oob_reg    <= rd_oob_next;
        rsp_word_reg  <= rsp_word_next;
        hold_word_reg <= hold_word_next;
    end

`ifndef ASSERT_OFF
    // holding slot only fills behind a full output register
    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> rsp_valid_reg)
        else $error("holding slot valid with empty output register");

    // rebuilt corridor never exceeds the length limit
    a_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREFIX && pre_left_reg == '0) |-> (total_reg <= limit_reg))
        else $error("merged length above limit");

    // finishing a rebuild reports a merge
    a_merge_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREFIX && pre_left_reg == '0) |=> last_merged_reg)
        else $error("merge flag not set after rebuild");

    // the scan never disturbs the corridor
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !cor_we)
        else $error("corridor written during scan");

    // tail move never reads the word it writes in the same cycle
    a_copy_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (cor_we && cor_re) |-> (cor_waddr != cor_raddr))
        else $error("corridor read and write collide");
`endif

endmodule

`default_nettype wire

FILE: hdl/path_corridor_merge_top.sv
// Corridor merge unit.
// Request channel (req_valid/req_stall/req_word) takes one word per action:
// write corridor entry, write visited entry, merge, read corridor entry.
// Response channel (rsp_valid/rsp_stall/rsp_word) returns one word per action
// with the read data (zero unless a read) and the length and merged flag left
// by the most recent merge. cfg_we/cfg_data write max_length; the user must
// write it only while idle, as the block itself does not enforce it. A write's
// response is registered straight from the accepting cycle; a read's response
// first passes the corridor RAM read register and the read-wait state. A merge
// scans the corridor from its end, one RAM read per cycle against all visited
// entries at once, then moves the tail and writes the visited prefix through
// the single RAM write port. One action is in flight at a time; the next is
// taken once the current one has finished and the holding slot behind the
// output register is empty, even while a response still waits in the output
// register. A stalled response holds its word. Reset clears the control state,
// sets max_length to 256 and the reported length and flag to zero; the stores
// hold nothing meaningful until written.
`default_nettype none

module path_corridor_merge_top #(
    parameter int CORRIDOR_DEPTH = pcm_pkg::CORRIDOR_DEPTH_DEF,
    parameter int VISITED_DEPTH  = pcm_pkg::VISITED_DEPTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire pcm_pkg::pcm_in_t          req_word,
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output pcm_pkg::pcm_out_t              rsp_word,
    input  wire logic                      cfg_we,
    input  wire logic [pcm_pkg::LEN_W-1:0] cfg_data
);
    import pcm_pkg::*;

    localparam int AW  = $clog2(CORRIDOR_DEPTH);
    localparam int VW  = $clog2(VISITED_DEPTH);
    localparam int VCW = $clog2(VISITED_DEPTH + 1);

    logic             cor_we;
    logic [AW-1:0]    cor_waddr;
    logic [REF_W-1:0] cor_wdata;
    logic             cor_re;
    logic [AW-1:0]    cor_raddr;
    logic [REF_W-1:0] cor_rdata;
    logic             vis_we;
    logic [VW-1:0]    vis_waddr;
    logic [REF_W-1:0] vis_wdata;
    logic [VCW-1:0]   vis_count;
    logic             vis_hit;
    logic [VW-1:0]    vis_hit_idx;
    logic [VW-1:0]    vis_raddr;
    logic [REF_W-1:0] vis_rdata;

    // corridor store
    pcm_corridor_mem #(
        .DEPTH (CORRIDOR_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (cor_we),
        .waddr (cor_waddr),
        .wdata (cor_wdata),
        .re    (cor_re),
        .raddr (cor_raddr),
        .rdata (cor_rdata)
    );

    // visited list with parallel match against the corridor read word
    pcm_visited_file #(
        .DEPTH (VISITED_DEPTH),
        .VW    (VW),
        .VCW   (VCW)
    ) u_vis (
        .clk      (clk),
        .we       (vis_we),
        .waddr    (vis_waddr),
        .wdata    (vis_wdata),
        .count    (vis_count),
        .cmp_data (cor_rdata),
        .hit      (vis_hit),
        .hit_idx  (vis_hit_idx),
        .raddr    (vis_raddr),
        .rdata    (vis_rdata)
    );

    // sequencer and response stage
    pcm_merge_ctrl #(
        .CORRIDOR_DEPTH (CORRIDOR_DEPTH),
        .VISITED_DEPTH  (VISITED_DEPTH),
        .AW             (AW),
        .VW             (VW),
        .VCW            (VCW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_word    (req_word),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_word    (rsp_word),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .cor_we      (cor_we),
        .cor_waddr   (cor_waddr),
        .cor_wdata   (cor_wdata),
        .cor_re      (cor_re),
        .cor_raddr   (cor_raddr),
        .cor_rdata   (cor_rdata),
        .vis_we      (vis_we),
        .vis_waddr   (vis_waddr),
        .vis_wdata   (vis_wdata),
        .vis_count   (vis_count),
        .vis_hit     (vis_hit),
        .vis_hit_idx (vis_hit_idx),
        .vis_raddr   (vis_raddr),
        .vis_rdata   (vis_rdata)
    );

endmodule

`default_nettype wire
